@@ rtl/cdp_pkg.sv @@
// cdp_pkg: shared types and constants for the control datagram parser
// holds the result record, kind and error codes, and queue sizing
// no dependencies
`timescale 1ns / 1ps

package cdp_pkg;

  // queue between parser front and output back; depth must be a power of two
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam int unsigned MAGIC_W   = 32;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    KIND_CMD     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERR     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC   = 2'd0,
    ERR_LENGTH  = 2'd1,
    ERR_HEADER  = 2'd2,
    ERR_PAYLOAD = 2'd3
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] command;
    logic [15:0] cmd_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
    err_t        error_code;
  } rec_t;

endpackage

@@ rtl/cdp_front.sv @@
// cdp_front: per-byte datagram parser, magic/length checks and header decode
// emits at most one result record per accepted byte
// depends on cdp_pkg
`timescale 1ns / 1ps

module cdp_front
  import cdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [MAGIC_W-1:0] magic,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic [15:0]        total_length,
  output logic               res_valid,
  output rec_t               res
);

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_PAD     = 3'd3,
    PH_IDLE    = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] field_shift, field_shift_next;
  logic [1:0]  field_count, field_count_next;
  logic [15:0] payload_left, payload_left_next;
  logic [1:0]  pad_left, pad_left_next;
  logic [15:0] cur_cmd, cur_cmd_next;
  logic [15:0] cur_len, cur_len_next;

  logic        fail;
  err_t        fail_code;
  logic [15:0] fail_cmd, fail_len;
  logic [15:0] hdr_len, hdr_cmd;

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    field_shift_next  = field_shift;
    field_count_next  = field_count;
    payload_left_next = payload_left;
    pad_left_next     = pad_left;
    cur_cmd_next      = cur_cmd;
    cur_len_next      = cur_len;
    fail              = 1'b0;
    fail_code         = ERR_MAGIC;
    fail_cmd          = '0;
    fail_len          = '0;
    res_valid         = 1'b0;
    res               = '0;
    hdr_len           = field_shift[23:8];
    hdr_cmd           = {field_shift[7:0], data_byte};

    if (accept) begin
      if (first_byte) begin
        phase_next        = PH_MAGIC;
        bytes_left_next   = total_length;
        field_shift_next  = '0;
        field_count_next  = '0;
        payload_left_next = '0;
        pad_left_next     = '0;
        cur_cmd_next      = '0;
        cur_len_next      = '0;
        if (total_length < 16'd4) begin
          fail = 1'b1;
        end
      end

      // working values are the *_next values after a possible restart
      if (!fail && bytes_left_next != '0 && phase_next != PH_IDLE) begin
        case (phase_next)
          PH_MAGIC: begin
            bytes_left_next  = bytes_left_next - 16'd1;
            field_shift_next = {field_shift_next[23:0], data_byte};
            field_count_next = field_count_next + 2'd1;
            if (field_count_next == 2'd0) begin
              if (field_shift_next != magic) begin
                fail = 1'b1;
              end else if (bytes_left_next[1:0] != 2'd0) begin
                fail      = 1'b1;
                fail_code = ERR_LENGTH;
              end else begin
                field_shift_next = '0;
                phase_next       = PH_HEADER;
              end
            end
          end
          PH_HEADER: begin
            if (field_count == 2'd0 && bytes_left < 16'd4) begin
              fail      = 1'b1;
              fail_code = ERR_HEADER;
            end else begin
              bytes_left_next  = bytes_left - 16'd1;
              field_shift_next = {field_shift[23:0], data_byte};
              field_count_next = field_count + 2'd1;
              if (field_count_next == 2'd0) begin
                field_shift_next = '0;
                if (hdr_len > bytes_left_next) begin
                  fail      = 1'b1;
                  fail_code = ERR_PAYLOAD;
                  fail_cmd  = hdr_cmd;
                  fail_len  = hdr_len;
                end else begin
                  cur_cmd_next      = hdr_cmd;
                  cur_len_next      = hdr_len;
                  payload_left_next = hdr_len;
                  pad_left_next     = 2'd0 - hdr_len[1:0];
                  phase_next        = (hdr_len != '0) ? PH_PAYLOAD : PH_HEADER;
                  res_valid          = 1'b1;
                  res.kind           = KIND_CMD;
                  res.command        = hdr_cmd;
                  res.cmd_length     = hdr_len;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            bytes_left_next   = bytes_left - 16'd1;
            payload_left_next = payload_left - 16'd1;
            if (payload_left_next == '0) begin
              phase_next = (pad_left != 2'd0) ? PH_PAD : PH_HEADER;
            end
            res_valid          = 1'b1;
            res.kind           = KIND_PAYLOAD;
            res.command        = cur_cmd;
            res.cmd_length     = cur_len;
            res.payload_byte   = data_byte;
            res.payload_last   = (payload_left_next == '0);
          end
          PH_PAD: begin
            bytes_left_next = bytes_left - 16'd1;
            pad_left_next   = pad_left - 2'd1;
            if (pad_left_next == 2'd0) begin
              phase_next = PH_HEADER;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end

      if (fail) begin
        bytes_left_next    = '0;
        phase_next         = PH_IDLE;
        res_valid          = 1'b1;
        res                = '0;
        res.kind           = KIND_ERR;
        res.error_code     = fail_code;
        res.command        = fail_cmd;
        res.cmd_length     = fail_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC;
      bytes_left   <= '0;
      field_shift  <= '0;
      field_count  <= '0;
      payload_left <= '0;
      pad_left     <= '0;
      cur_cmd      <= '0;
      cur_len      <= '0;
    end else begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      field_shift  <= field_shift_next;
      field_count  <= field_count_next;
      payload_left <= payload_left_next;
      pad_left     <= pad_left_next;
      cur_cmd      <= cur_cmd_next;
      cur_len      <= cur_len_next;
    end
  end

endmodule

@@ rtl/cdp_fifo.sv @@
// cdp_fifo: small register queue of result records between front and back
// depends on cdp_pkg
`timescale 1ns / 1ps

module cdp_fifo
  import cdp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic empty,
  output rec_t head
);

  rec_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count, count_next;
  logic           do_push, do_pop;

  assign full    = (count == QCW'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + QCW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

@@ rtl/cdp_back.sv @@
// cdp_back: output register that drains the record queue onto the stream bus
// depends on cdp_pkg
`timescale 1ns / 1ps

module cdp_back
  import cdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  rec_t                  q_head,
  output logic                  q_pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  output logic [1:0]            m_axis_tuser
);

  rec_t out_rec;

  assign q_pop = !q_empty && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_rec <= q_head;
    end
  end

  assign m_axis_tdata = {6'd0, out_rec.error_code, out_rec.payload_byte,
                         out_rec.cmd_length, out_rec.command};
  assign m_axis_tlast = out_rec.payload_last;
  assign m_axis_tuser = out_rec.kind;

endmodule

@@ rtl/control_datagram_parser.sv @@
// control_datagram_parser: top level of the control datagram decoder
// instantiates cdp_front, cdp_fifo and cdp_back; depends on cdp_pkg
`timescale 1ns / 1ps

// Decodes control datagrams fed one byte per word on the slave stream. The
// word that carries tuser=1 opens a datagram and gives its total length. The
// first four bytes must match magic_data (big-endian); the remaining length
// must be a multiple of four. Each 4-byte header (length, then command, both
// big-endian) yields a command record (tuser=0), each payload byte a payload
// word (tuser=1, tlast on the final byte), and padding is skipped silently.
// The first error (tuser=2) ends the datagram; the rest of its bytes are
// dropped. A new first byte abandons any datagram in progress. One byte is
// taken every cycle while the queue has room: the parser decides each byte
// combinationally and writes its record into a four-entry queue, from
// which the output register hands it to the master stream. The slave side
// only stalls when that queue is full, i.e. when the master side has held
// off for a while. magic_data is sampled on any cycle with magic_wr high;
// change it only while no datagram is in flight.

module control_datagram_parser
  import cdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  // configuration
  input  logic                  magic_wr,
  input  logic [MAGIC_W-1:0]    magic_data,

  // byte input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], total_length[23:8]
  input  logic                  s_axis_tuser,  // first_byte

  // result output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // command[15:0], cmd_length[31:16], payload_byte[39:32],
  // error_code[41:40], zero fill[47:42]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,  // payload_last
  output logic [1:0]            m_axis_tuser   // kind
);

  logic [MAGIC_W-1:0] magic;
  logic               accept;
  logic               res_valid;
  rec_t               res;
  logic               q_full, q_empty, q_pop;
  rec_t               q_head;

  // magic register, cleared to zero on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      magic <= '0;
    end else if (magic_wr) begin
      magic <= magic_data;
    end
  end

  // front accepts whenever the queue has room for a possible record
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cdp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .magic        (magic),
    .accept       (accept),
    .data_byte    (s_axis_tdata[7:0]),
    .first_byte   (s_axis_tuser),
    .total_length (s_axis_tdata[23:8]),
    .res_valid    (res_valid),
    .res          (res)
  );

  // decouples parsing from the output handshake
  cdp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_rec (res),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  cdp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ rtl/cdp_checker.sv @@
// cdp_checker: port-level assertions for control_datagram_parser
// bound to the top level below; depends on cdp_pkg
`timescale 1ns / 1ps

module cdp_checker
  import cdp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic [1:0]            m_axis_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // last marker only on payload words
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_PAYLOAD)
    else $error("tlast on a non-payload word");

  // error code and payload byte zero outside their kinds
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_ERR |-> m_axis_tdata[41:40] == 2'd0)
    else $error("error code set on a non-error word");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tdata[39:32] == 8'd0)
    else $error("payload byte set on a non-payload word");

  // only defined kinds leave the block
  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == KIND_CMD || m_axis_tuser == KIND_PAYLOAD
                      || m_axis_tuser == KIND_ERR)
    else $error("undefined kind on output");

endmodule

bind control_datagram_parser cdp_checker u_cdp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/cdp_scoreboard_pkg.sv @@
// cdp_scoreboard_pkg: record scoreboard for the control datagram parser bench
// predicts the parser's records byte by byte and checks them in order; needs cdp_pkg
`timescale 1ns / 1ps

package cdp_scoreboard_pkg;
  import cdp_pkg::*;

  typedef enum logic [2:0] {
    ST_MAGIC,
    ST_HEADER,
    ST_PAYLOAD,
    ST_PAD,
    ST_IDLE
  } parse_stage_t;

  class record_scoreboard;
    rec_t         pending_records[$];
    logic [31:0]  magic;
    parse_stage_t stage;
    logic [15:0]  bytes_left;
    logic [31:0]  field_shift;
    logic [1:0]   field_count;
    logic [15:0]  payload_left;
    logic [1:0]   pad_left;
    logic [15:0]  cur_cmd;
    logic [15:0]  cur_len;
    int unsigned  used_bytes;
    int unsigned  checked;
    int unsigned  errors;

    function new();
      magic = '0;
      used_bytes = 0;
      checked = 0;
      errors = 0;
      clear_datagram();
    endfunction

    function void set_magic(logic [31:0] value);
      magic = value;
    endfunction

    function void clear_datagram();
      stage = ST_MAGIC;
      bytes_left = '0;
      field_shift = '0;
      field_count = '0;
      payload_left = '0;
      pad_left = '0;
      cur_cmd = '0;
      cur_len = '0;
    endfunction

    // report an error and drop the rest of the datagram
    function rec_t drop_datagram(err_t code, logic [15:0] cmd, logic [15:0] len);
      rec_t r;
      bytes_left = '0;
      stage = ST_IDLE;
      r = '0;
      r.kind = KIND_ERR;
      r.command = cmd;
      r.cmd_length = len;
      r.error_code = code;
      return r;
    endfunction

    function bit parse_byte(input logic [7:0] b, input logic is_first,
                            input logic [15:0] total, output rec_t r);
      logic [15:0] hlen;
      logic [15:0] hcmd;
      r = '0;
      if (is_first) begin
        clear_datagram();
        bytes_left = total;
        if (total < 16'd4) begin
          r = drop_datagram(ERR_MAGIC, '0, '0);
          return 1;
        end
      end
      if (bytes_left == '0 || stage == ST_IDLE) return 0;
      case (stage)
        ST_MAGIC: begin
          bytes_left = bytes_left - 16'd1;
          field_shift = {field_shift[23:0], b};
          field_count = field_count + 2'd1;
          if (field_count != 2'd0) return 0;
          if (field_shift != magic) begin
            r = drop_datagram(ERR_MAGIC, '0, '0);
            return 1;
          end
          if (bytes_left[1:0] != 2'd0) begin
            r = drop_datagram(ERR_LENGTH, '0, '0);
            return 1;
          end
          field_shift = '0;
          stage = ST_HEADER;
          return 0;
        end
        ST_HEADER: begin
          if (field_count == 2'd0 && bytes_left < 16'd4) begin
            r = drop_datagram(ERR_HEADER, '0, '0);
            return 1;
          end
          bytes_left = bytes_left - 16'd1;
          field_shift = {field_shift[23:0], b};
          field_count = field_count + 2'd1;
          if (field_count != 2'd0) return 0;
          hlen = field_shift[31:16];
          hcmd = field_shift[15:0];
          field_shift = '0;
          if (hlen > bytes_left) begin
            r = drop_datagram(ERR_PAYLOAD, hcmd, hlen);
            return 1;
          end
          cur_cmd = hcmd;
          cur_len = hlen;
          payload_left = hlen;
          pad_left = 2'd0 - hlen[1:0];
          stage = (hlen != '0) ? ST_PAYLOAD : ST_HEADER;
          r.kind = KIND_CMD;
          r.command = hcmd;
          r.cmd_length = hlen;
          return 1;
        end
        ST_PAYLOAD: begin
          bytes_left = bytes_left - 16'd1;
          payload_left = payload_left - 16'd1;
          if (payload_left == '0) stage = (pad_left != '0) ? ST_PAD : ST_HEADER;
          r.kind = KIND_PAYLOAD;
          r.command = cur_cmd;
          r.cmd_length = cur_len;
          r.payload_byte = b;
          r.payload_last = (payload_left == '0);
          return 1;
        end
        ST_PAD: begin
          bytes_left = bytes_left - 16'd1;
          pad_left = pad_left - 2'd1;
          if (pad_left == '0) stage = ST_HEADER;
          return 0;
        end
        default: return 0;
      endcase
    endfunction

    // called for every accepted input word
    function void accept_byte(logic [7:0] b, logic is_first, logic [15:0] total);
      rec_t r;
      if (is_first || (bytes_left != '0 && stage != ST_IDLE)) used_bytes++;
      if (parse_byte(b, is_first, total, r)) pending_records.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // called for every accepted output word
    function void check_record(rec_t got);
      rec_t want;
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_records.pop_front();
      checked++;
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("command", want.command, got.command);
      compare_field("cmd_length", want.cmd_length, got.cmd_length);
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("payload_last", 16'(want.payload_last), 16'(got.payload_last));
      compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
    endfunction
  endclass

endpackage

@@ tb/tb_control_datagram_parser.sv @@
// tb_control_datagram_parser: self-checking bench for control_datagram_parser
// drives datagrams byte by byte with random gaps and output stalls; needs cdp_pkg,
// cdp_scoreboard_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_control_datagram_parser;
  import cdp_pkg::*;
  import cdp_scoreboard_pkg::*;

  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned NUM_SETTINGS = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        magic_wr = 1'b0;
  logic [31:0] magic_data = '0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // data_byte[7:0], total_length[23:8]
  logic        s_axis_tuser = 1'b0;  // first_byte
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // command[15:0], cmd_length[31:16], payload_byte[39:32], error_code[41:40]
  wire  [47:0] m_axis_tdata;
  wire         m_axis_tlast;  // payload_last
  wire  [1:0]  m_axis_tuser;  // kind

  control_datagram_parser dut (
    .clk           (clk),
    .rst           (rst),
    .magic_wr      (magic_wr),
    .magic_data    (magic_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  record_scoreboard sb;

  // datagram under construction and how much of it goes out
  logic [7:0]  dgram[$];
  logic [15:0] dgram_total;
  int unsigned send_len;
  logic [31:0] cur_magic = '0;

  // sender burst state; quiet_run turns the gaps off for a whole datagram
  int unsigned burst_left = 0;
  bit          quiet_run = 1'b0;

  int unsigned n_dgrams = 0;
  int unsigned n_good = 0;
  int unsigned cycles = 0;

  // receiver stall pattern: mode and how long it lasts
  int unsigned sink_mode = 0;
  int unsigned sink_left = 0;

  rec_t seen_rec;

  initial begin
    forever #5 clk = ~clk;
  end

  // timeout guard
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** control_datagram_parser: FAILED **");
    $finish;
  end

  // receiver: each mode holds for a while, from always ready to one beat in 16
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(32, 200);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (sink_left[3:0] == 4'd0);
    endcase
  end

  // monitor: values seen here are the ones sampled at this edge
  always @(posedge clk) begin
    if (!rst) begin
      // input word first so the prediction is in place before any output
      if (s_axis_tvalid && s_axis_tready)
        sb.accept_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tdata[23:8]);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_rec.kind           = kind_t'(m_axis_tuser);
        seen_rec.command        = m_axis_tdata[15:0];
        seen_rec.cmd_length     = m_axis_tdata[31:16];
        seen_rec.payload_byte   = m_axis_tdata[39:32];
        seen_rec.payload_last   = m_axis_tlast;
        seen_rec.error_code     = err_t'(m_axis_tdata[41:40]);
        sb.check_record(seen_rec);
      end
    end
  end

  // one input word; opens a gap first when the current burst is used up
  task send_word(input logic [7:0] d, input logic f, input logic [15:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet_run ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, d};
    s_axis_tuser  <= f;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // first send_len bytes of dgram; total_length on non-first words is noise
  task send_datagram();
    for (int i = 0; i < send_len; i++)
      send_word(dgram[i], i == 0, (i == 0) ? dgram_total : 16'($urandom));
    n_dgrams++;
  endtask

  // drain everything, let the parser settle, then write the magic register
  task set_magic(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    magic_wr   <= 1'b1;
    magic_data <= value;
    @(posedge clk);
    magic_wr <= 1'b0;
    sb.set_magic(value);
    cur_magic = value;
  endtask

  task put_half(input logic [15:0] v);
    dgram.push_back(v[15:8]);
    dgram.push_back(v[7:0]);
  endtask

  // header, payload and padding up to a four-byte boundary
  task put_command(input logic [15:0] len, input logic [15:0] cmd);
    put_half(len);
    put_half(cmd);
    repeat (len) dgram.push_back(8'($urandom));
    while (dgram.size() % 4 != 0) dgram.push_back(8'($urandom));
  endtask

  // big-endian magic word opens every datagram
  task start_datagram();
    dgram = {};
    put_half(cur_magic[31:16]);
    put_half(cur_magic[15:0]);
  endtask

  initial begin
    int v;
    int k;
    int c;
    logic [15:0] plen;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // zero and all-ones first, then random magic words
      case (p)
        0: set_magic(32'h0000_0000);
        1: set_magic(32'hFFFF_FFFF);
        default: set_magic($urandom);
      endcase

      if (p == 0) begin
        // stray word with no datagram open is dropped
        send_word(8'hFF, 1'b0, 16'hFFFF);
        // empty and short datagrams fail on their first byte
        send_word(8'hA5, 1'b1, 16'd0);
        send_word(8'h00, 1'b1, 16'd3);
        send_word(8'h5A, 1'b0, 16'd0);
        // well formed: empty payload command, then a one-byte payload with padding
        start_datagram();
        put_command(16'd0, 16'hFFFF);
        put_command(16'd1, 16'h0000);
        dgram[12] = 8'hFF;
        dgram_total = 16'(dgram.size());
        send_len = dgram.size();
        send_datagram();
        n_good++;
        // wrong magic
        start_datagram();
        dgram[3] = dgram[3] ^ 8'h80;
        dgram_total = 16'd4;
        send_len = 4;
        send_datagram();
        // length after magic not a multiple of four
        start_datagram();
        dgram.push_back(8'h00);
        dgram_total = 16'd5;
        send_len = 5;
        send_datagram();
      end

      while (sb.used_bytes < (p + 1) * ITEM_TARGET / NUM_SETTINGS) begin
        quiet_run = ($urandom_range(0, 3) == 0);
        start_datagram();
        repeat ($urandom_range(0, 4)) begin
          plen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(10, 40))
                                             : 16'($urandom_range(0, 9));
          put_command(plen, 16'($urandom));
        end
        dgram_total = 16'(dgram.size());
        send_len = dgram.size();
        v = $urandom_range(0, 99);
        if (v < 60) begin
          n_good++;
        end else if (v < 68) begin
          // one flipped bit in the magic word
          k = $urandom_range(0, 3);
          dgram[k] = dgram[k] ^ (8'h01 << $urandom_range(0, 7));
        end else if (v < 74) begin
          // one to three stray bytes make the length not a multiple of four
          repeat ($urandom_range(1, 3)) dgram.push_back(8'($urandom));
          dgram_total = 16'(dgram.size());
          send_len = dgram.size();
        end else if (v < 82) begin
          // header asks for more payload than the datagram still holds
          plen = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                      : 16'($urandom_range(1, 12));
          c = $urandom_range(0, 2);
          if (plen <= c * 4) plen = 16'(c * 4 + 1);
          put_half(plen);
          put_half(16'($urandom));
          repeat (c * 4) dgram.push_back(8'($urandom));
          dgram_total = 16'(dgram.size());
          send_len = dgram.size();
        end else if (v < 88) begin
          // cut short; the next first byte abandons it
          send_len = $urandom_range(1, dgram.size());
        end else if (v < 92) begin
          // bytes past the end are ignored
          repeat ($urandom_range(1, 6)) dgram.push_back(8'($urandom));
          send_len = dgram.size();
        end else if (v < 96) begin
          // total below four, rest of the bytes dropped
          dgram_total = 16'($urandom_range(0, 3));
          send_len = (dgram.size() < 6) ? dgram.size() : $urandom_range(1, 6);
        end else begin
          // large total length, random header, left open for the next datagram
          put_half(16'($urandom));
          put_half(16'($urandom));
          repeat (8) dgram.push_back(8'($urandom));
          dgram_total = 16'($urandom) | 16'h8000;
          send_len = dgram.size();
        end
        send_datagram();
      end
    end

    // wait out the last records, then the pipeline depth
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d datagrams (%0d well formed) under %0d magic settings",
             n_dgrams, n_good, NUM_SETTINGS);
    $display("%0d bytes parsed, %0d records checked, %0d mismatches",
             sb.used_bytes, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("** control_datagram_parser: PASSED **");
    end else begin
      $display("** control_datagram_parser: FAILED **");
    end
    $finish;
  end

endmodule

@@ control_datagram_parser.f @@
rtl/cdp_pkg.sv
rtl/cdp_front.sv
rtl/cdp_fifo.sv
rtl/cdp_back.sv
rtl/control_datagram_parser.sv
rtl/cdp_checker.sv
tb/cdp_scoreboard_pkg.sv
tb/tb_control_datagram_parser.sv
